/* design/tidu_pkg.sv */
// tidu_pkg: shared widths, codes and handshake structs of the tickless idle deadline unit
// used by tidu_iter and tickless_idle_deadline_unit, depends on nothing

package tidu_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned TickW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CntW    = 6;

  localparam logic [TickW-1:0] PeriodReset = 32'd10000;
  localparam logic [TickW-1:0] MinIdle     = 32'd2;
  localparam logic [TickW-1:0] OneTick     = 32'd1;

  localparam logic [ModeW-1:0] ModeStart = 2'd0;
  localparam logic [ModeW-1:0] ModeSleep = 2'd1;
  localparam logic [ModeW-1:0] ModeWake  = 2'd2;

  localparam logic [StatusW-1:0] StArmed       = 3'd0;
  localparam logic [StatusW-1:0] StIgnored     = 3'd1;
  localparam logic [StatusW-1:0] StAborted     = 3'd2;
  localparam logic [StatusW-1:0] StSleeping    = 3'd3;
  localparam logic [StatusW-1:0] StWokeDeadline = 3'd4;
  localparam logic [StatusW-1:0] StWokeEarly   = 3'd5;
  localparam logic [StatusW-1:0] StError       = 3'd6;

  localparam logic [CntW-1:0] DivSteps = 6'd63;
  localparam logic [CntW-1:0] MulSteps = 6'd31;

  typedef enum logic {
    ITER_MUL,
    ITER_DIV
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_rsp_t;

endpackage

/* design/tickless_idle_deadline_unit.sv */
// tickless_idle_deadline_unit: timer compare deadlines for periodic ticks and tickless idle
// sequencer around tidu_iter; uses tidu_pkg
//
//  channel | ports                                   | handshake
//  in      | in_mode in_now in_idle_ticks in_abort_sleep | in_valid / in_ready
//  out     | out_status out_compare_write out_compare_value out_step_ticks | out_valid / out_ready
//  cfg     | cfg_wdata (tick_period)                 | cfg_we, no wait
//
// one word at a time; start, ignored, veto, stray wake and wake at deadline go straight to emit
// a sleep with a tick due stops at the compare; an early wake before the boundary goes to finish
// a sleep runs the boundary compare, then the shift-add multiply, then the finish step
// an early wake runs the divide then the multiply (only the divide if too late)
// reset is synchronous on rst_n and clears tick_period to 10000 and all timer state
// a finished word waits in the output register; the last step stalls until it is free

module tickless_idle_deadline_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tidu_pkg::ModeW-1:0]        in_mode,
  input  logic [tidu_pkg::TimeW-1:0]        in_now,
  input  logic [tidu_pkg::TickW-1:0]        in_idle_ticks,
  input  logic                              in_abort_sleep,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tidu_pkg::StatusW-1:0]      out_status,
  output logic                              out_compare_write,
  output logic [tidu_pkg::TimeW-1:0]        out_compare_value,
  output logic [tidu_pkg::TickW-1:0]        out_step_ticks,
  input  logic                              cfg_we,
  input  logic [tidu_pkg::TickW-1:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SLP_CMP,
    S_MUL_SLP,
    S_SLP_FIN,
    S_DIV,
    S_MUL_WAKE,
    S_WAKE_FIN,
    S_EMIT
  } state_t;

  state_t                           state_r;
  logic [tidu_pkg::TickW-1:0]       tick_period_r;
  logic [tidu_pkg::TimeW-1:0]       next_time_r;
  logic                             sleep_pending_r;
  logic [tidu_pkg::TimeW-1:0]       saved_boundary_r;
  logic [tidu_pkg::TimeW-1:0]       saved_deadline_r;
  logic [tidu_pkg::TickW-1:0]       saved_idle_r;

  logic [tidu_pkg::ModeW-1:0]       mode_r;
  logic [tidu_pkg::TimeW-1:0]       now_r;
  logic [tidu_pkg::TickW-1:0]       idle_r;
  logic                             veto_r;
  logic [tidu_pkg::TimeW-1:0]       bnd_r;
  logic [tidu_pkg::TimeW-1:0]       tmp_r;
  logic [tidu_pkg::TickW-1:0]       elapsed_r;

  logic [tidu_pkg::StatusW-1:0]     res_status_r;
  logic                             res_wr_r;
  logic [tidu_pkg::TickW-1:0]       res_step_r;

  logic                             out_valid_r;
  logic [tidu_pkg::StatusW-1:0]     out_status_r;
  logic                             out_wr_r;
  logic [tidu_pkg::TimeW-1:0]       out_value_r;
  logic [tidu_pkg::TickW-1:0]       out_step_r;

  logic [tidu_pkg::TickW-1:0]       p;
  logic [tidu_pkg::TimeW-1:0]       p64;
  tidu_pkg::iter_req_t              iter_req;
  tidu_pkg::iter_rsp_t              iter_rsp;
  logic [tidu_pkg::TimeW-1:0]       iter_opa;
  logic [tidu_pkg::TimeW-1:0]       iter_res;
  logic                             wake_due;
  logic                             wake_in_window;
  logic                             div_bad;
  logic [tidu_pkg::TickW-1:0]       elapsed_nxt;

  assign p   = (tick_period_r == '0) ? tidu_pkg::OneTick : tick_period_r;
  assign p64 = {{(tidu_pkg::TimeW-tidu_pkg::TickW){1'b0}}, p};

  assign wake_due       = (now_r >= saved_deadline_r);
  assign wake_in_window = (now_r >= saved_boundary_r);
  assign div_bad        = (saved_idle_r == '0) ||
                          (iter_res >= {{(tidu_pkg::TimeW-tidu_pkg::TickW){1'b0}},
                                        saved_idle_r - tidu_pkg::OneTick});
  assign elapsed_nxt    = iter_res[tidu_pkg::TickW-1:0] + tidu_pkg::OneTick;

  // requests to the shared unit
  always_comb begin
    iter_req.start = 1'b0;
    iter_req.op    = tidu_pkg::ITER_MUL;
    iter_opa       = '0;
    case (state_r)
      S_EXEC: begin
        if (mode_r == tidu_pkg::ModeWake && sleep_pending_r && !wake_due && wake_in_window) begin
          iter_req.start = 1'b1;
          iter_req.op    = tidu_pkg::ITER_DIV;
          iter_opa       = now_r - saved_boundary_r;
        end
      end
      S_SLP_CMP: begin
        if (now_r < bnd_r) begin
          iter_req.start = 1'b1;
          iter_opa = {{(tidu_pkg::TimeW-tidu_pkg::TickW){1'b0}}, idle_r - tidu_pkg::OneTick};
        end
      end
      S_DIV: begin
        if (iter_rsp.done && !div_bad) begin
          iter_req.start = 1'b1;
          iter_opa = {{(tidu_pkg::TimeW-tidu_pkg::TickW){1'b0}}, elapsed_nxt};
        end
      end
      default: begin
        iter_req.start = 1'b0;
      end
    endcase
  end

  tidu_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (iter_req),
    .opa    (iter_opa),
    .opb    (p),
    .rsp    (iter_rsp),
    .result (iter_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      tick_period_r    <= tidu_pkg::PeriodReset;
      next_time_r      <= '0;
      sleep_pending_r  <= 1'b0;
      saved_boundary_r <= '0;
      saved_deadline_r <= '0;
      saved_idle_r     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_period_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            now_r   <= in_now;
            idle_r  <= in_idle_ticks;
            veto_r  <= in_abort_sleep;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (mode_r)
            tidu_pkg::ModeStart: begin
              res_status_r    <= tidu_pkg::StArmed;
              res_wr_r        <= 1'b1;
              tmp_r           <= now_r + p64;
              res_step_r      <= '0;
              next_time_r     <= now_r + {p64[tidu_pkg::TimeW-2:0], 1'b0};
              sleep_pending_r <= 1'b0;
              state_r         <= S_EMIT;
            end
            tidu_pkg::ModeSleep: begin
              res_wr_r   <= 1'b0;
              res_step_r <= '0;
              if (idle_r < tidu_pkg::MinIdle) begin
                res_status_r <= tidu_pkg::StIgnored;
                state_r      <= S_EMIT;
              end else if (veto_r) begin
                res_status_r <= tidu_pkg::StAborted;
                state_r      <= S_EMIT;
              end else begin
                bnd_r   <= next_time_r - p64;
                state_r <= S_SLP_CMP;
              end
            end
            tidu_pkg::ModeWake: begin
              res_wr_r <= 1'b0;
              if (!sleep_pending_r) begin
                res_status_r <= tidu_pkg::StError;
                res_step_r   <= '0;
                state_r      <= S_EMIT;
              end else begin
                sleep_pending_r <= 1'b0;
                if (wake_due) begin
                  res_status_r <= tidu_pkg::StWokeDeadline;
                  res_step_r   <= saved_idle_r - tidu_pkg::OneTick;
                  state_r      <= S_EMIT;
                end else if (wake_in_window) begin
                  res_step_r <= '0;
                  state_r    <= S_DIV;
                end else if (saved_idle_r == '0) begin
                  res_status_r <= tidu_pkg::StError;
                  res_step_r   <= '0;
                  state_r      <= S_EMIT;
                end else begin
                  elapsed_r  <= '0;
                  tmp_r      <= saved_boundary_r;
                  res_step_r <= '0;
                  state_r    <= S_WAKE_FIN;
                end
              end
            end
            default: begin
              res_status_r <= tidu_pkg::StIgnored;
              res_wr_r     <= 1'b0;
              res_step_r   <= '0;
              state_r      <= S_EMIT;
            end
          endcase
        end
        S_SLP_CMP: begin
          if (now_r >= bnd_r) begin
            res_status_r <= tidu_pkg::StAborted;
            state_r      <= S_EMIT;
          end else begin
            state_r <= S_MUL_SLP;
          end
        end
        S_MUL_SLP: begin
          if (iter_rsp.done) begin
            tmp_r   <= bnd_r + iter_res;
            state_r <= S_SLP_FIN;
          end
        end
        S_SLP_FIN: begin
          next_time_r      <= tmp_r + p64;
          sleep_pending_r  <= 1'b1;
          saved_boundary_r <= bnd_r;
          saved_deadline_r <= tmp_r;
          saved_idle_r     <= idle_r;
          res_status_r     <= tidu_pkg::StSleeping;
          res_wr_r         <= 1'b1;
          state_r          <= S_EMIT;
        end
        S_DIV: begin
          if (iter_rsp.done) begin
            if (div_bad) begin
              res_status_r <= tidu_pkg::StError;
              state_r      <= S_EMIT;
            end else begin
              elapsed_r <= elapsed_nxt;
              state_r   <= S_MUL_WAKE;
            end
          end
        end
        S_MUL_WAKE: begin
          if (iter_rsp.done) begin
            tmp_r   <= saved_boundary_r + iter_res;
            state_r <= S_WAKE_FIN;
          end
        end
        S_WAKE_FIN: begin
          next_time_r  <= tmp_r + p64;
          res_status_r <= tidu_pkg::StWokeEarly;
          res_wr_r     <= 1'b1;
          res_step_r   <= elapsed_r;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_wr_r     <= res_wr_r;
            out_value_r  <= res_wr_r ? tmp_r : '0;
            out_step_r   <= res_step_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_compare_write = out_wr_r;
  assign out_compare_value = out_value_r;
  assign out_step_ticks    = out_step_r;

  // shared unit only runs while the sequencer waits on it
  a_iter_owned: assert property (@(posedge clk) disable iff (!rst_n)
    iter_rsp.busy |-> (state_r == S_DIV || state_r == S_MUL_SLP || state_r == S_MUL_WAKE))
    else $error("shared unit busy outside a wait state");

  // a sleep is recorded only by the sleep finishing step
  a_pending_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sleep_pending_r) |-> $past(state_r == S_SLP_FIN))
    else $error("sleep pending set outside sleep finish");

  // no compare value without a compare write
  a_value_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_compare_write) |-> (out_compare_value == '0))
    else $error("compare value without compare write");

  // compare writes come only with armed, sleeping or early wake
  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_write) |->
      (out_status == tidu_pkg::StArmed || out_status == tidu_pkg::StSleeping ||
       out_status == tidu_pkg::StWokeEarly))
    else $error("compare write with wrong status");

endmodule

/* design/tidu_iter.sv */
// tidu_iter: shared shift-add / shift-subtract unit, one bit per cycle
// 64 by 32 restoring divide, 32 by 32 multiply; uses tidu_pkg

module tidu_iter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tidu_pkg::iter_req_t             req,
  input  logic [tidu_pkg::TimeW-1:0]      opa,
  input  logic [tidu_pkg::TickW-1:0]      opb,
  output tidu_pkg::iter_rsp_t             rsp,
  output logic [tidu_pkg::TimeW-1:0]      result
);

  logic                         busy_r;
  logic                         done_r;
  tidu_pkg::iter_op_t           op_r;
  logic [tidu_pkg::CntW-1:0]    cnt_r;
  logic [tidu_pkg::TickW-1:0]   rem_r;
  logic [tidu_pkg::TimeW-1:0]   q_r;
  logic [tidu_pkg::TickW-1:0]   b_r;

  logic                         is_div;
  logic [tidu_pkg::TickW:0]     x;
  logic [tidu_pkg::TickW:0]     y;
  logic [tidu_pkg::TickW+1:0]   sum;
  logic [tidu_pkg::TickW-1:0]   rem_nxt;
  logic [tidu_pkg::TimeW-1:0]   q_nxt;

  assign is_div = (op_r == tidu_pkg::ITER_DIV);

  // one shared 33 bit adder, subtracting for divide
  always_comb begin
    if (is_div) begin
      x = {rem_r, q_r[tidu_pkg::TimeW-1]};
      y = ~{1'b0, b_r};
    end else begin
      x = {1'b0, rem_r};
      y = q_r[0] ? {1'b0, b_r} : '0;
    end
    sum = {1'b0, x} + {1'b0, y} + {{(tidu_pkg::TickW+1){1'b0}}, is_div};
    if (is_div) begin
      rem_nxt = sum[tidu_pkg::TickW+1] ? sum[tidu_pkg::TickW-1:0] : x[tidu_pkg::TickW-1:0];
      q_nxt   = {q_r[tidu_pkg::TimeW-2:0], sum[tidu_pkg::TickW+1]};
    end else begin
      rem_nxt = sum[tidu_pkg::TickW:1];
      q_nxt   = {q_r[tidu_pkg::TimeW-1:tidu_pkg::TickW], sum[0], q_r[tidu_pkg::TickW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= tidu_pkg::ITER_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        rem_r  <= '0;
        q_r    <= opa;
        b_r    <= opb;
        cnt_r  <= (req.op == tidu_pkg::ITER_DIV) ? tidu_pkg::DivSteps : tidu_pkg::MulSteps;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = is_div ? q_r : {rem_r, q_r[tidu_pkg::TickW-1:0]};

endmodule

/* sim/tickless_idle_deadline_unit_tb.sv */
// tickless_idle_deadline_unit_tb: self-checking bench for the tickless idle deadline unit
// directed table then random start/sleep/wake sequences over several tick periods,
// each word checked against a local deadline predictor or a fixed row response; needs tidu_pkg and the dut

module tickless_idle_deadline_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ModeW   = tidu_pkg::ModeW;
  localparam int unsigned TimeW   = tidu_pkg::TimeW;
  localparam int unsigned TickW   = tidu_pkg::TickW;
  localparam int unsigned StatusW = tidu_pkg::StatusW;

  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [TickW-1:0] IdleMax = '1;
  localparam int NumRows = 23;
  localparam int RandPerPhase = 325;
  localparam int NumPhases = 6;
  localparam int HoldCycles = 400;
  localparam int QuietLimit = 4000;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [TimeW-1:0] now;
    logic [TickW-1:0] idle;
    logic             veto;
  } tick_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               cmp_wr;
    logic [TimeW-1:0]   cmp_val;
    logic [TickW-1:0]   step;
  } tick_rsp_t;

  typedef struct packed {
    tick_req_t req;
    logic      has_fixed;
    tick_rsp_t fixed;
  } dir_row_t;

  localparam tick_rsp_t RspIgnored = '{tidu_pkg::StIgnored, 1'b0, '0, '0};
  localparam tick_rsp_t RspAborted = '{tidu_pkg::StAborted, 1'b0, '0, '0};
  localparam tick_rsp_t RspError   = '{tidu_pkg::StError, 1'b0, '0, '0};
  localparam tick_rsp_t RspArmed0  = '{tidu_pkg::StArmed, 1'b1, 64'd10000, '0};
  localparam tick_rsp_t RspNone    = '0;

  // predictor rows only carry a fixed response where it is obvious
  dir_row_t dir_rows [NumRows] = '{
    '{'{tidu_pkg::ModeWake,  64'd0,     32'd0,      1'b0}, 1'b1, RspError},
    '{'{ModeSpare,           TimeMax,   IdleMax,    1'b1}, 1'b1, RspIgnored},
    '{'{tidu_pkg::ModeStart, 64'd0,     32'd0,      1'b0}, 1'b1, RspArmed0},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd0,      1'b0}, 1'b1, RspIgnored},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd1,      1'b0}, 1'b1, RspIgnored},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd2,      1'b1}, 1'b1, RspAborted},
    '{'{tidu_pkg::ModeSleep, 64'd10000, 32'd2,      1'b0}, 1'b1, RspAborted},
    '{'{tidu_pkg::ModeSleep, 64'd9999,  32'd2,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd3,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeWake,  64'd40000, 32'd0,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeWake,  64'd0,     32'd0,      1'b0}, 1'b1, RspError},
    '{'{tidu_pkg::ModeStart, TimeMax,   IdleMax,    1'b1}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeSleep, 64'd0,     IdleMax,    1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeWake,  64'd34999, 32'd0,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd4,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeWake,  64'd0,     32'd0,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeStart, 64'd0,     32'd0,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd2,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeStart, 64'd5,     32'd0,      1'b1}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeWake,  64'd0,     32'd0,      1'b0}, 1'b1, RspError},
    '{'{tidu_pkg::ModeSleep, 64'd0,     32'd2,      1'b0}, 1'b0, RspNone},
    '{'{tidu_pkg::ModeWake,  TimeMax,   IdleMax,    1'b1}, 1'b0, RspNone},
    '{'{ModeSpare,           64'd0,     32'd0,      1'b0}, 1'b1, RspIgnored}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ModeW-1:0]    in_mode;
  logic [TimeW-1:0]    in_now;
  logic [TickW-1:0]    in_idle_ticks;
  logic                in_abort_sleep;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [StatusW-1:0]  out_status;
  logic                out_compare_write;
  logic [TimeW-1:0]    out_compare_value;
  logic [TickW-1:0]    out_step_ticks;
  logic                cfg_we;
  logic [TickW-1:0]    cfg_wdata;

  // predictor state
  logic [TickW-1:0] tb_period;
  logic [TimeW-1:0] tb_next_tick;
  logic             tb_sleeping;
  logic [TimeW-1:0] tb_boundary;
  logic [TimeW-1:0] tb_deadline;
  logic [TickW-1:0] tb_idle;

  tick_rsp_t due_rsp_q [$];
  tick_rsp_t mon_want;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        seq_pos = 0;
  logic      steady = 1'b0;
  int        stall_reqs = 0;
  int        stall_seen = 0;
  int        hold_left = 0;

  tickless_idle_deadline_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_now            (in_now),
    .in_idle_ticks     (in_idle_ticks),
    .in_abort_sleep    (in_abort_sleep),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_compare_write (out_compare_write),
    .out_compare_value (out_compare_value),
    .out_step_ticks    (out_step_ticks),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TimeW-1:0] eff_period();
    return (tb_period == '0) ? 64'd1 : {32'd0, tb_period};
  endfunction

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic tick_rsp_t compute_deadline(input tick_req_t req);
    tick_rsp_t        rsp;
    logic [TimeW-1:0] p;
    logic [TimeW-1:0] first;
    logic [TimeW-1:0] boundary;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] q;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] restored;
    logic             bad;
    p = eff_period();
    rsp = RspIgnored;
    bad = 1'b0;
    elapsed = '0;
    case (req.mode)
      tidu_pkg::ModeStart: begin
        first = req.now + p;
        tb_next_tick = first + p;
        tb_sleeping = 1'b0;
        rsp = '{tidu_pkg::StArmed, 1'b1, first, '0};
      end
      tidu_pkg::ModeSleep: begin
        boundary = tb_next_tick - p;
        if (req.idle < tidu_pkg::MinIdle) begin
          rsp = RspIgnored;
        end else if (req.veto || req.now >= boundary) begin
          rsp = RspAborted;
        end else begin
          deadline = boundary + {32'd0, req.idle - tidu_pkg::OneTick} * p;
          tb_next_tick = deadline + p;
          tb_sleeping = 1'b1;
          tb_boundary = boundary;
          tb_deadline = deadline;
          tb_idle = req.idle;
          rsp = '{tidu_pkg::StSleeping, 1'b1, deadline, '0};
        end
      end
      tidu_pkg::ModeWake: begin
        if (!tb_sleeping) begin
          rsp = RspError;
        end else begin
          tb_sleeping = 1'b0;
          if (req.now >= tb_deadline) begin
            rsp = '{tidu_pkg::StWokeDeadline, 1'b0, '0, tb_idle - tidu_pkg::OneTick};
          end else begin
            if (req.now >= tb_boundary) begin
              q = (req.now - tb_boundary) / p;
              if (tb_idle == '0 || q >= {32'd0, tb_idle} - 64'd1) bad = 1'b1;
              else elapsed = q + 64'd1;
            end else if (tb_idle == '0) begin
              bad = 1'b1;
            end
            if (bad) begin
              rsp = RspError;
            end else begin
              restored = tb_boundary + elapsed * p;
              tb_next_tick = restored + p;
              rsp = '{tidu_pkg::StWokeEarly, 1'b1, restored, elapsed[TickW-1:0]};
            end
          end
        end
      end
      default: rsp = RspIgnored;
    endcase
    return rsp;
  endfunction

  // mostly start -> sleep -> wake chains aimed at the live state, the rest noise
  function automatic tick_req_t random_word();
    tick_req_t        r;
    logic [TimeW-1:0] p;
    logic [TimeW-1:0] bd;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] off;
    p = eff_period();
    r.mode = ModeW'($urandom_range(0, 3));
    r.now = rand64();
    r.idle = ($urandom_range(0, 3) == 0) ? TickW'($urandom_range(0, 1)) : TickW'($urandom);
    r.veto = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 80) begin
      off = rand64() >> $urandom_range(0, 63);
      case (seq_pos)
        0: begin
          r.mode = tidu_pkg::ModeStart;
          if ($urandom_range(0, 1) == 1) r.now = off;
          seq_pos = 1;
        end
        1: begin
          r.mode = tidu_pkg::ModeSleep;
          bd = tb_next_tick - p;
          if (off >= bd) off = '0;
          r.now = bd - 64'd1 - off;
          r.idle = ($urandom_range(0, 7) == 0) ? TickW'($urandom) : TickW'($urandom_range(2, 24));
          r.veto = ($urandom_range(0, 19) == 0);
          seq_pos = 2;
        end
        default: begin
          r.mode = tidu_pkg::ModeWake;
          span = tb_deadline - tb_boundary;
          case ($urandom_range(0, 3))
            0: r.now = tb_deadline + (($urandom_range(0, 3) == 0) ? off : 64'($urandom_range(0, 50)));
            1: r.now = tb_deadline - 64'd1;
            2: r.now = tb_boundary + ((span == '0) ? '0 : off % span);
            default: begin
              if (off >= tb_boundary) off = '0;
              r.now = tb_boundary - 64'd1 - off;
            end
          endcase
          seq_pos = ($urandom_range(0, 3) == 0) ? 0 : 1;
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] got,
                             input logic [TimeW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input tick_req_t req, input logic has_fixed, input tick_rsp_t fixed);
    tick_rsp_t want;
    in_mode = req.mode;
    in_now = req.now;
    in_idle_ticks = req.idle;
    in_abort_sleep = req.veto;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    want = compute_deadline(req);
    if (has_fixed) want = fixed;
    due_rsp_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic wait_idle(input int settle);
    in_valid = 1'b0;
    while (due_rsp_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_period(input logic [TickW-1:0] value);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    tb_period = value;
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      hold_left = HoldCycles;
      out_ready = 1'b0;
    end else begin
      out_ready = steady || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, status %0d", out_status));
      end else begin
        mon_want = due_rsp_q.pop_front();
        check_field("status", 64'(out_status), 64'(mon_want.status));
        check_field("compare_write", 64'(out_compare_write), 64'(mon_want.cmp_wr));
        check_field("compare_value", out_compare_value, mon_want.cmp_val);
        check_field("step_ticks", 64'(out_step_ticks), 64'(mon_want.step));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("tickless_idle_deadline_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = tidu_pkg::ModeStart;
    in_now = '0;
    in_idle_ticks = '0;
    in_abort_sleep = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tb_period = tidu_pkg::PeriodReset;
    tb_next_tick = '0;
    tb_sleeping = 1'b0;
    tb_boundary = '0;
    tb_deadline = '0;
    tb_idle = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumRows; i++) begin
      sender_gap();
      send_word(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle(8);
      case (ph)
        0: write_period(32'd1);
        1: write_period(32'd0);
        2: write_period(IdleMax);
        3: write_period(TickW'($urandom_range(2, 1000)));
        4: write_period(TickW'($urandom));
        default: write_period(tidu_pkg::PeriodReset);
      endcase
      seq_pos = 0;
      for (int n = 0; n < RandPerPhase; n++) begin
        steady = (ph == 1 && n < 150);
        if (ph == 2 && n == 100) stall_reqs++;
        sender_gap();
        send_word(random_word(), 1'b0, RspNone);
      end
      steady = 1'b0;
    end

    wait_idle(120);
    if (mismatches == 0) begin
      $display("tickless_idle_deadline_unit_tb: PASS");
    end else begin
      $display("tickless_idle_deadline_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
